>>> rtl/core/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
// Used by tccw_front, tccw_back and text_console_cell_writer_top; no dependencies.

package tccw_pkg;

    // Fixed field widths of the item and result ports.
    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 7;
    localparam int CELL_W  = 16;

    // Cell address width for the largest grid (64 rows of 128 columns).
    localparam int ADDR_W = 13;

    // Item kinds as they arrive on the kind port.
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;

    localparam logic [2:0] TAB_STEPS = 3'd5;

    // Classified operation handed from the front to the back.
    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_TAB,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CELL_W-1:0] cell_data;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADV,
        ST_SCROLL,
        ST_SCR_CLR,
        ST_CLEAR,
        ST_RD,
        ST_DONE
    } state_t;

endpackage

>>> rtl/core/tccw_front.sv
// Front end of the console: accepts items, classifies them and holds them in a
// two-entry command queue for the back end. Depends on tccw_pkg.

module tccw_front #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [tccw_pkg::KIND_W-1:0]  kind,
    input  logic [tccw_pkg::CHAR_W-1:0]  char_code,
    input  logic [tccw_pkg::COLOR_W-1:0] color,
    input  logic [tccw_pkg::ROW_W-1:0]   read_row,
    input  logic [tccw_pkg::COL_W-1:0]   read_col,
    input  logic                         init_busy,
    output logic                         cmd_valid,
    output tccw_pkg::cmd_t               cmd,
    input  logic                         cmd_take
);

    tccw_pkg::cmd_t queue_reg [0:1];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    tccw_pkg::cmd_t new_cmd;
    logic           accept;
    logic           in_grid;

    assign full      = (count_reg == 2'd2) || init_busy;
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = queue_reg[rd_ptr_reg];

    assign in_grid = (32'(read_row) < 32'(ROWS)) && (32'(read_col) < 32'(COLS));

    always_comb
    begin
        new_cmd.cell_data = {color, char_code};
        new_cmd.addr = tccw_pkg::ADDR_W'(read_row) * tccw_pkg::ADDR_W'(COLS)
                       + tccw_pkg::ADDR_W'(read_col);
        priority if (kind == tccw_pkg::KIND_PUT)
        begin
            if (char_code == tccw_pkg::CH_NEWLINE)
                new_cmd.op = tccw_pkg::OP_NEWLINE;
            else if (char_code == tccw_pkg::CH_TAB)
                new_cmd.op = tccw_pkg::OP_TAB;
            else
                new_cmd.op = tccw_pkg::OP_CHAR;
        end
        else if (kind == tccw_pkg::KIND_CLEAR)
            new_cmd.op = tccw_pkg::OP_CLEAR;
        else if (kind == tccw_pkg::KIND_READ && in_grid)
            new_cmd.op = tccw_pkg::OP_READ;
        else
            new_cmd.op = tccw_pkg::OP_NOP;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
            wr_ptr_next = !wr_ptr_reg;
        if (cmd_take && cmd_valid)
            rd_ptr_next = !rd_ptr_reg;
        if (accept && !(cmd_take && cmd_valid))
            count_next = count_reg + 2'd1;
        else if (!accept && cmd_take && cmd_valid)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            queue_reg[wr_ptr_reg] <= new_cmd;
    end

endmodule

>>> rtl/core/tccw_back.sv
// Back end of the console: cursor, cell memory, clear and scroll sweeps, and the
// result register. Takes classified commands from tccw_front; depends on tccw_pkg.

module tccw_back #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  tccw_pkg::cmd_t               cmd,
    output logic                         cmd_take,
    output logic                         init_busy,
    input  logic                         pop,
    output logic                         empty,
    output logic [tccw_pkg::CELL_W-1:0]  cell_value,
    output logic [tccw_pkg::ROW_W-1:0]   cursor_row,
    output logic [tccw_pkg::COL_W-1:0]   cursor_col,
    output logic                         scrolled
);

    localparam int CELLS  = ROWS * COLS;
    localparam int AW     = $clog2(CELLS);
    localparam int MOVE_N = (ROWS - 1) * COLS;

    localparam logic [AW-1:0] LAST_ADDR   = AW'(CELLS - 1);
    localparam logic [AW-1:0] MOVE_END    = AW'(MOVE_N);
    localparam logic [AW-1:0] COLS_A      = AW'(COLS);
    localparam logic [AW-1:0] COL_LAST_A  = AW'(COLS - 1);
    localparam logic [tccw_pkg::ROW_W-1:0] ROW_LAST = tccw_pkg::ROW_W'(ROWS - 1);
    localparam logic [tccw_pkg::COL_W-1:0] COL_LAST = tccw_pkg::COL_W'(COLS - 1);

    logic [tccw_pkg::CELL_W-1:0] mem [0:CELLS-1];

    tccw_pkg::state_t            state_reg, state_next;
    logic [tccw_pkg::ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [tccw_pkg::COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [AW-1:0]               cur_addr_reg, cur_addr_next;
    logic [2:0]                  steps_reg, steps_next;
    logic                        scr_reg, scr_next;
    logic [AW-1:0]               sweep_reg, sweep_next;
    logic                        mv_valid_reg, mv_valid_next;
    logic [AW-1:0]               mv_addr_reg, mv_addr_next;
    logic [tccw_pkg::CELL_W-1:0] res_cell_reg, res_cell_next;
    logic [tccw_pkg::CELL_W-1:0] rd_data_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [tccw_pkg::CELL_W-1:0] out_cell_reg, out_cell_next;
    logic [tccw_pkg::ROW_W-1:0]  out_row_reg, out_row_next;
    logic [tccw_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic                        out_scr_reg, out_scr_next;

    logic                        we;
    logic [AW-1:0]               waddr;
    logic [tccw_pkg::CELL_W-1:0] wdata;
    logic [AW-1:0]               raddr;

    assign init_busy  = (state_reg == tccw_pkg::ST_INIT);
    assign empty      = !out_valid_reg;
    assign cell_value = out_cell_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;
    assign scrolled   = out_scr_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cur_addr_next  = cur_addr_reg;
        steps_next     = steps_reg;
        scr_next       = scr_reg;
        sweep_next     = sweep_reg;
        mv_valid_next  = 1'b0;
        mv_addr_next   = mv_addr_reg;
        res_cell_next  = res_cell_reg;
        out_valid_next = out_valid_reg;
        out_cell_next  = out_cell_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_scr_next   = out_scr_reg;
        cmd_take       = 1'b0;
        we             = 1'b0;
        waddr          = cur_addr_reg;
        wdata          = '0;
        raddr          = cmd.addr[AW-1:0];

        if (pop && out_valid_reg)
            out_valid_next = 1'b0;

        unique case (state_reg)
            tccw_pkg::ST_INIT:
            begin
                we    = 1'b1;
                waddr = sweep_reg;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == LAST_ADDR)
                    state_next = tccw_pkg::ST_IDLE;
            end

            tccw_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take      = 1'b1;
                    scr_next      = 1'b0;
                    res_cell_next = '0;
                    steps_next    = 3'd1;
                    unique case (cmd.op)
                        tccw_pkg::OP_CHAR:
                        begin
                            we         = 1'b1;
                            wdata      = cmd.cell_data;
                            state_next = tccw_pkg::ST_ADV;
                        end
                        tccw_pkg::OP_NEWLINE:
                        begin
                            // Jump to the last column so one advance lands on the next row.
                            cur_col_next  = COL_LAST;
                            cur_addr_next = cur_addr_reg - AW'(cur_col_reg) + COL_LAST_A;
                            state_next    = tccw_pkg::ST_ADV;
                        end
                        tccw_pkg::OP_TAB:
                        begin
                            steps_next = tccw_pkg::TAB_STEPS;
                            state_next = tccw_pkg::ST_ADV;
                        end
                        tccw_pkg::OP_CLEAR:
                        begin
                            sweep_next    = '0;
                            cur_row_next  = '0;
                            cur_col_next  = '0;
                            cur_addr_next = '0;
                            state_next    = tccw_pkg::ST_CLEAR;
                        end
                        tccw_pkg::OP_READ:
                            state_next = tccw_pkg::ST_RD;
                        tccw_pkg::OP_NOP:
                            state_next = tccw_pkg::ST_DONE;
                        default:
                            state_next = tccw_pkg::ST_DONE;
                    endcase
                end
            end

            tccw_pkg::ST_ADV:
            begin
                steps_next = steps_reg - 3'd1;
                state_next = (steps_reg == 3'd1) ? tccw_pkg::ST_DONE : tccw_pkg::ST_ADV;
                if (cur_col_reg == COL_LAST)
                begin
                    cur_col_next = '0;
                    if (cur_row_reg == ROW_LAST)
                    begin
                        scr_next      = 1'b1;
                        sweep_next    = '0;
                        cur_addr_next = MOVE_END;
                        state_next    = tccw_pkg::ST_SCROLL;
                    end
                    else
                    begin
                        cur_row_next  = cur_row_reg + tccw_pkg::ROW_W'(1);
                        cur_addr_next = cur_addr_reg + AW'(1);
                    end
                end
                else
                begin
                    cur_col_next  = cur_col_reg + tccw_pkg::COL_W'(1);
                    cur_addr_next = cur_addr_reg + AW'(1);
                end
            end

            tccw_pkg::ST_SCROLL:
            begin
                // Read one row below, write the data to the current row in the next cycle.
                raddr = sweep_reg + COLS_A;
                we    = mv_valid_reg;
                waddr = mv_addr_reg;
                wdata = rd_data_reg;
                if (sweep_reg == MOVE_END)
                    state_next = tccw_pkg::ST_SCR_CLR;
                else
                begin
                    mv_valid_next = 1'b1;
                    mv_addr_next  = sweep_reg;
                    sweep_next    = sweep_reg + AW'(1);
                end
            end

            tccw_pkg::ST_SCR_CLR:
            begin
                we    = 1'b1;
                waddr = sweep_reg;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == LAST_ADDR)
                    state_next = (steps_reg == 3'd0) ? tccw_pkg::ST_DONE : tccw_pkg::ST_ADV;
            end

            tccw_pkg::ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = sweep_reg;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == LAST_ADDR)
                    state_next = tccw_pkg::ST_DONE;
            end

            tccw_pkg::ST_RD:
            begin
                res_cell_next = rd_data_reg;
                state_next    = tccw_pkg::ST_DONE;
            end

            tccw_pkg::ST_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = res_cell_reg;
                    out_row_next   = cur_row_reg;
                    out_col_next   = cur_col_reg;
                    out_scr_next   = scr_reg;
                    state_next     = tccw_pkg::ST_IDLE;
                end
            end

            default:
                state_next = tccw_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tccw_pkg::ST_INIT;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            cur_addr_reg  <= '0;
            steps_reg     <= 3'd0;
            scr_reg       <= 1'b0;
            sweep_reg     <= '0;
            mv_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            cur_addr_reg  <= cur_addr_next;
            steps_reg     <= steps_next;
            scr_reg       <= scr_next;
            sweep_reg     <= sweep_next;
            mv_valid_reg  <= mv_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_addr_reg  <= mv_addr_next;
        res_cell_reg <= res_cell_next;
        out_cell_reg <= out_cell_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_scr_reg  <= out_scr_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
    end

endmodule

>>> rtl/core/text_console_cell_writer_top.sv
// Top level of the text console cell writer: front classifier and back executor.
// Depends on tccw_pkg, tccw_front and tccw_back.
//
// Usage: items enter through a queue-style port (push/full) and each gives exactly
// one result, read from a queue-style port (empty/pop) with the oldest result first.
// A transfer happens on a rising edge with push high and full low on the input
// side, or pop high and empty low on the output side.
// A two-entry command queue sits between the front and the back, so items keep
// being taken while the back works or a result waits to be popped.
// The back takes one item at a time: a read fetches the addressed cell, a printable
// character is written and the cursor advances, a newline advances from the last
// column, and a tab advances TAB_STEPS columns. Each scroll adds a memory sweep
// (one cell move per cycle through the single write port), and a clear sweeps
// every cell of the memory.
// After reset the cell memory is zeroed in one pass over every cell; full stays
// high meanwhile. When the receiver does not pop, the held result stalls the back,
// the command queue fills, and full rises.

module text_console_cell_writer_top #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [tccw_pkg::KIND_W-1:0]  kind,
    input  logic [tccw_pkg::CHAR_W-1:0]  char_code,
    input  logic [tccw_pkg::COLOR_W-1:0] color,
    input  logic [tccw_pkg::ROW_W-1:0]   read_row,
    input  logic [tccw_pkg::COL_W-1:0]   read_col,
    output logic                         empty,
    input  logic                         pop,
    output logic [tccw_pkg::CELL_W-1:0]  cell_value,
    output logic [tccw_pkg::ROW_W-1:0]   cursor_row,
    output logic [tccw_pkg::COL_W-1:0]   cursor_col,
    output logic                         scrolled
);

    logic           cmd_valid;
    logic           cmd_take;
    logic           init_busy;
    tccw_pkg::cmd_t cmd;

    tccw_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .char_code (char_code),
        .color     (color),
        .read_row  (read_row),
        .read_col  (read_col),
        .init_busy (init_busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    tccw_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take),
        .init_busy  (init_busy),
        .pop        (pop),
        .empty      (empty),
        .cell_value (cell_value),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled)
    );

endmodule
